@@ rtl/core/vwma_pkg.sv @@
package vwma_pkg;

   localparam int RING_DEPTH = 256;

   localparam int DATA_W  = 32;
   localparam int SUM_W   = 48;
   localparam int ADDR_W  = $clog2(RING_DEPTH);
   localparam int COUNT_W = $clog2(RING_DEPTH + 1);
   // Quotient bits needed to tell whether the target window saturates.
   localparam int QUOT_W  = ADDR_W;
   localparam int ITER_W  = $clog2(DATA_W + 1);

   localparam logic [DATA_W-1:0] SAMPLE_PERIOD_RESET = DATA_W'(65536);
   localparam logic [DATA_W-1:0] AVG_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] AVG_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TGT_CHK,
      ST_TGT_DIV,
      ST_TGT_FIN,
      ST_MOVE,
      ST_SUB_OLD,
      ST_SUB_NEXT,
      ST_WRITE,
      ST_AVG_CHK,
      ST_AVG_DIV,
      ST_OUT
   } state_type;

   // Ring address of the entry written back_by items before write_index.
   function automatic logic [ADDR_W-1:0] ring_back_addr(input logic [ADDR_W-1:0] wr_idx,
                                                        input logic [COUNT_W-1:0] back_by);
      logic [COUNT_W:0] wide_idx;
      logic [COUNT_W:0] wide_back;
      logic [COUNT_W:0] res;
      wide_idx  = (COUNT_W + 1)'(wr_idx);
      wide_back = (COUNT_W + 1)'(back_by);
      if (wide_back == (COUNT_W + 1)'(RING_DEPTH)) begin
         res = wide_idx;
      end else if (wide_idx >= wide_back) begin
         res = wide_idx - wide_back;
      end else begin
         res = wide_idx + (COUNT_W + 1)'(RING_DEPTH) - wide_back;
      end
      return res[ADDR_W-1:0];
   endfunction

   function automatic logic [SUM_W-1:0] sext_sample(input logic [DATA_W-1:0] s);
      return {{(SUM_W-DATA_W){s[DATA_W-1]}}, s};
   endfunction

endpackage

@@ rtl/core/vwma_req_if.sv @@
interface vwma_req_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  sample_in;
   logic signed [31:0]  avg_period;

   modport source (output valid, output sample_in, output avg_period, input ready);
   modport sink   (input valid, input sample_in, input avg_period, output ready);
endinterface

@@ rtl/core/vwma_rsp_if.sv @@
interface vwma_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  average_out;

   modport source (output valid, output average_out, input ready);
   modport sink   (input valid, input average_out, output ready);
endinterface

@@ rtl/core/variable_window_moving_average.sv @@
// Variable-window moving average over signed Q16.16 samples. Each request item carries a
// sample and a requested averaging period; each produces exactly one response item with
// the window average, truncated toward zero and saturated to 32 bits, or zero when the
// period is not positive (then no state changes). csr_write_data sets the sampling
// interval (unsigned Q16.16, reset 1.0) and may only be written while the block is idle.
// The block takes its next item only after the current one is loaded into the output
// register. One restoring shift-subtract divider, one bit per cycle, first produces the
// 8 quotient bits of period / sampling interval (for a 256-entry ring), then 32 bits of
// running sum / window count; the other steps are the target check and finish, the
// accumulator update, up to two ring reads, the ring write, the average check and the
// output load. A period of at least 256 sampling intervals, or a zero interval, skips the
// first division and its finish step; a holding window skips one ring read and a growing
// one skips both; an average that must saturate skips the second division.
// A non-positive period goes from acceptance straight to the output load, which waits
// while an earlier response has not been taken. The response sits in an output register,
// so the next request is taken while it waits.
// No clearing pass is needed after reset: a fill count marks which ring entries hold data.
module variable_window_moving_average (
   input  logic                 clock,
   input  logic                 reset,
   vwma_req_if.sink             req_chan,
   vwma_rsp_if.source           rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [31:0]          csr_write_data
);

   localparam int DW = vwma_pkg::DATA_W;
   localparam int SW = vwma_pkg::SUM_W;
   localparam int AW = vwma_pkg::ADDR_W;
   localparam int CW = vwma_pkg::COUNT_W;
   localparam int QW = vwma_pkg::QUOT_W;
   localparam int IW = vwma_pkg::ITER_W;

   vwma_pkg::state_type state_ff, state_in;

   // Configuration.
   logic [DW-1:0] sp_ff;

   // Filter state.
   logic [DW-1:0] ring_mem [vwma_pkg::RING_DEPTH];
   logic [DW-1:0] ring_rd_ff;
   logic [AW-1:0] wi_ff, wi_in;
   logic [CW-1:0] wc_ff, wc_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [DW-1:0] prev_ff, prev_in;

   // Per-item working registers.
   logic [DW-1:0] sample_ff, sample_in;
   logic [DW-1:0] period_ff, period_in;
   logic [CW-1:0] target_ff, target_in;
   logic          shrink_ff, shrink_in;
   logic          zero_ff, zero_in;
   logic          ovf_ff, ovf_in;
   logic          neg_ff, neg_in;

   // Shared divider.
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] div_ff, div_in;
   logic [SW-1:0] dvd_ff, dvd_in;
   logic [DW-1:0] quot_ff, quot_in;
   logic [IW-1:0] cnt_ff, cnt_in;

   // Output register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_data_ff, rsp_data_in;

   // Ring port controls.
   logic          ring_re;
   logic [AW-1:0] ring_raddr;
   logic          ring_we;

   // Divider step.
   logic [DW:0]   step_sh;
   logic [DW:0]   step_diff;
   logic          step_ge;
   logic [DW-1:0] step_rem;

   // Misc combinational.
   logic [SW-1:0] sum_mag;
   logic [DW-1:0] result;
   logic          accept;

   assign step_sh   = {rem_ff, dvd_ff[SW-1]};
   assign step_ge   = step_sh >= {1'b0, div_ff};
   assign step_diff = step_sh - {1'b0, div_ff};
   assign step_rem  = step_ge ? step_diff[DW-1:0] : step_sh[DW-1:0];

   assign sum_mag = sum_ff[SW-1] ? (~sum_ff + SW'(1)) : sum_ff;
   assign accept  = req_chan.valid && req_chan.ready;

   assign req_chan.ready       = (state_ff == vwma_pkg::ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.average_out = rsp_data_ff;

   // Final average from the divider, with saturation to the signed 32-bit range, or zero for a non-positive period.
   always_comb begin
      if (zero_ff) begin
         result = '0;
      end else if (ovf_ff) begin
         result = neg_ff ? vwma_pkg::AVG_MIN : vwma_pkg::AVG_MAX;
      end else if (!neg_ff) begin
         result = quot_ff[DW-1] ? vwma_pkg::AVG_MAX : quot_ff;
      end else if (quot_ff > vwma_pkg::AVG_MIN) begin
         result = vwma_pkg::AVG_MIN;
      end else begin
         result = ~quot_ff + DW'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      wi_in        = wi_ff;
      wc_in        = wc_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      prev_in      = prev_ff;
      sample_in    = sample_ff;
      period_in    = period_ff;
      target_in    = target_ff;
      shrink_in    = shrink_ff;
      zero_in      = zero_ff;
      ovf_in       = ovf_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      dvd_in       = dvd_ff;
      quot_in      = quot_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ring_re      = 1'b0;
      ring_raddr   = vwma_pkg::ring_back_addr(wi_ff, wc_ff);
      ring_we      = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         vwma_pkg::ST_IDLE: begin
            if (accept) begin
               sample_in = req_chan.sample_in;
               period_in = req_chan.avg_period;
               ovf_in    = 1'b0;
               neg_in    = 1'b0;
               if (req_chan.avg_period[DW-1] || (req_chan.avg_period == '0)) begin
                  zero_in  = 1'b1;
                  state_in = vwma_pkg::ST_OUT;
               end else begin
                  zero_in  = 1'b0;
                  state_in = vwma_pkg::ST_TGT_CHK;
               end
            end
         end
         vwma_pkg::ST_TGT_CHK: begin
            // A quotient of at least 2^QW always saturates the window.
            if ((sp_ff == '0) ||
                ({{QW{1'b0}}, period_ff} >= {sp_ff, {QW{1'b0}}})) begin
               target_in = CW'(vwma_pkg::RING_DEPTH);
               state_in  = vwma_pkg::ST_MOVE;
            end else begin
               rem_in   = DW'(period_ff >> QW);
               dvd_in   = {period_ff[QW-1:0], {(SW-QW){1'b0}}};
               div_in   = sp_ff;
               quot_in  = '0;
               cnt_in   = IW'(QW);
               state_in = vwma_pkg::ST_TGT_DIV;
            end
         end
         vwma_pkg::ST_TGT_DIV: begin
            rem_in  = step_rem;
            dvd_in  = {dvd_ff[SW-2:0], 1'b0};
            quot_in = {quot_ff[DW-2:0], step_ge};
            cnt_in  = cnt_ff - IW'(1);
            if (cnt_ff == IW'(1)) begin
               state_in = vwma_pkg::ST_TGT_FIN;
            end
         end
         vwma_pkg::ST_TGT_FIN: begin
            if (quot_ff >= DW'(vwma_pkg::RING_DEPTH - 1)) begin
               target_in = CW'(vwma_pkg::RING_DEPTH);
            end else begin
               target_in = CW'(quot_ff) + CW'(1);
            end
            state_in = vwma_pkg::ST_MOVE;
         end
         vwma_pkg::ST_MOVE: begin
            // The previous sample enters the window; the oldest entry is fetched unless the window grows.
            sum_in    = sum_ff + vwma_pkg::sext_sample(prev_ff);
            shrink_in = (target_ff < wc_ff);
            if (target_ff > wc_ff) begin
               wc_in    = wc_ff + CW'(1);
               state_in = vwma_pkg::ST_WRITE;
            end else begin
               ring_re  = 1'b1;
               state_in = vwma_pkg::ST_SUB_OLD;
            end
         end
         vwma_pkg::ST_SUB_OLD: begin
            // Entries not yet written since reset are not subtracted, as if they held zero.
            if (wc_ff <= fill_ff) begin
               sum_in = sum_ff - vwma_pkg::sext_sample(ring_rd_ff);
            end
            if (shrink_ff) begin
               ring_re    = 1'b1;
               ring_raddr = vwma_pkg::ring_back_addr(wi_ff, wc_ff - CW'(1));
               state_in   = vwma_pkg::ST_SUB_NEXT;
            end else begin
               state_in = vwma_pkg::ST_WRITE;
            end
         end
         vwma_pkg::ST_SUB_NEXT: begin
            if ((wc_ff - CW'(1)) <= fill_ff) begin
               sum_in = sum_ff - vwma_pkg::sext_sample(ring_rd_ff);
            end
            wc_in    = wc_ff - CW'(1);
            state_in = vwma_pkg::ST_WRITE;
         end
         vwma_pkg::ST_WRITE: begin
            ring_we = 1'b1;
            prev_in = sample_ff;
            wi_in   = (wi_ff == AW'(vwma_pkg::RING_DEPTH - 1)) ? '0 : wi_ff + AW'(1);
            if (fill_ff != CW'(vwma_pkg::RING_DEPTH)) begin
               fill_in = fill_ff + CW'(1);
            end
            state_in = vwma_pkg::ST_AVG_CHK;
         end
         vwma_pkg::ST_AVG_CHK: begin
            // The window count is at least one here.
            neg_in = sum_ff[SW-1];
            if (sum_mag >= SW'({wc_ff, {DW{1'b0}}})) begin
               ovf_in   = 1'b1;
               state_in = vwma_pkg::ST_OUT;
            end else begin
               rem_in   = DW'(sum_mag[SW-1:DW]);
               dvd_in   = {sum_mag[DW-1:0], {(SW-DW){1'b0}}};
               div_in   = DW'(wc_ff);
               quot_in  = '0;
               cnt_in   = IW'(DW);
               state_in = vwma_pkg::ST_AVG_DIV;
            end
         end
         vwma_pkg::ST_AVG_DIV: begin
            rem_in  = step_rem;
            dvd_in  = {dvd_ff[SW-2:0], 1'b0};
            quot_in = {quot_ff[DW-2:0], step_ge};
            cnt_in  = cnt_ff - IW'(1);
            if (cnt_ff == IW'(1)) begin
               state_in = vwma_pkg::ST_OUT;
            end
         end
         vwma_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               state_in     = vwma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vwma_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vwma_pkg::ST_IDLE;
         sp_ff        <= vwma_pkg::SAMPLE_PERIOD_RESET;
         wi_ff        <= '0;
         wc_ff        <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wi_ff        <= wi_in;
         wc_ff        <= wc_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            sp_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      period_ff   <= period_in;
      target_ff   <= target_in;
      shrink_ff   <= shrink_in;
      zero_ff     <= zero_in;
      ovf_ff      <= ovf_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      dvd_ff      <= dvd_in;
      quot_ff     <= quot_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Sample ring: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wi_ff] <= sample_ff;
      end
      if (ring_re) begin
         ring_rd_ff <= ring_mem[ring_raddr];
      end
   end

endmodule
